// ===== rtl/core/rbbd_pkg.sv =====
`default_nettype none

package rbbd_pkg;

   // Pixel and weight widths
   localparam int PixelWidth  = 16;
   localparam int WeightWidth = 8;
   localparam int PctWidth    = 7;

   // Configuration port
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   // Register index, taken from the word address bit of paddr
   localparam logic BrightnessIndex = 1'b0;

   // Blend arithmetic
   localparam logic [8:0]  WeightOne  = 9'd256;
   localparam logic [14:0] BlendRound = 15'd128;

   // Dimming arithmetic
   localparam logic [PctWidth-1:0] BrightnessReset = 7'd100;
   localparam logic [PctWidth-1:0] PercentFull     = 7'd100;
   localparam logic [12:0]         PercentRound    = 13'd50;

   // floor(x / 100) == (x * 5243) >> 19 for every x below 43690
   localparam logic [12:0] RecipMul   = 13'd5243;
   localparam int          RecipShift = 19;

   // (a * (256 - w) + b * w + 128) >> 8 on one channel of up to 6 bits
   function automatic logic [5:0] blend_ch(input logic [5:0] a,
                                           input logic [5:0] b,
                                           input logic [WeightWidth-1:0] w);
      logic [14:0] sum;
      sum = 15'(a) * 15'(WeightOne - 9'(w)) + 15'(b) * 15'(w) + BlendRound;
      return sum[13:8];
   endfunction

   // Blend two RGB565 pixels channel by channel
   function automatic logic [PixelWidth-1:0] blend_pixel(
      input logic [PixelWidth-1:0]  a,
      input logic [PixelWidth-1:0]  b,
      input logic [WeightWidth-1:0] w);
      logic [5:0] r;
      logic [5:0] g;
      logic [5:0] bl;
      r  = blend_ch({1'b0, a[15:11]}, {1'b0, b[15:11]}, w);
      g  = blend_ch(a[10:5], b[10:5], w);
      bl = blend_ch({1'b0, a[4:0]}, {1'b0, b[4:0]}, w);
      return {r[4:0], g, bl[4:0]};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rgb565_bilinear_blend_dimmer.sv =====
`default_nettype none

// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+------------------------------------------
// req_      | in        | req_valid / req_ready | top_left, top_right, bottom_left,
//           |           |                       | bottom_right (RGB565), weight_x, weight_y
// rsp_      | out       | rsp_valid / rsp_ready | pixel_out (RGB565)
// csr_      | in/out    | APB, pready tied high | brightness_percent at byte address 0
//
// Four register stages: horizontal blend, vertical blend, brightness product,
// reciprocal multiply for the divide by 100; one multiplier level per stage sets
// that depth. A req_ transfer in every cycle is sustained while rsp_ready is high.
// An item moves through the stage registers in order; rsp_valid is the last stage's valid bit.
// Reset clears the stage valid bits and loads brightness 100 (pass-through).
// A stall on rsp_ready backs up stage by stage; nothing is dropped or repeated.

module rgb565_bilinear_blend_dimmer (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [rbbd_pkg::PixelWidth-1:0]     req_top_left,
   input  wire logic [rbbd_pkg::PixelWidth-1:0]     req_top_right,
   input  wire logic [rbbd_pkg::PixelWidth-1:0]     req_bottom_left,
   input  wire logic [rbbd_pkg::PixelWidth-1:0]     req_bottom_right,
   input  wire logic [rbbd_pkg::WeightWidth-1:0]    req_weight_x,
   input  wire logic [rbbd_pkg::WeightWidth-1:0]    req_weight_y,

   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [rbbd_pkg::PixelWidth-1:0]     rsp_pixel_out,

   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [rbbd_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  wire logic [rbbd_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output      logic [rbbd_pkg::CsrDataWidth-1:0]   csr_prdata,
   output      logic                                csr_pready
);

   // ---------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------
   logic [rbbd_pkg::PctWidth-1:0] pct_ff;
   logic [rbbd_pkg::PctWidth-1:0] pct_in;
   logic                          csr_sel_bright;

   assign csr_pready     = 1'b1;
   assign csr_sel_bright = (csr_paddr[2] == rbbd_pkg::BrightnessIndex);

   always_comb begin
      pct_in = pct_ff;
      // Commit on the access phase of a write to the brightness word
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_bright) begin
         pct_in = csr_pwdata[rbbd_pkg::PctWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pct_ff <= rbbd_pkg::BrightnessReset;
      end else begin
         pct_ff <= pct_in;
      end
   end

   // Reads of any other word return zero
   assign csr_prdata = csr_sel_bright ?
                       rbbd_pkg::CsrDataWidth'(pct_ff) : '0;

   // ---------------------------------------------------------------
   // Stage flow control: a stage loads when empty or when it moves on
   // ---------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4 = !v4_ff || rsp_ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_ready = rdy1;
   assign rsp_valid = v4_ff;

   always_comb begin
      v1_in = rdy1 ? req_valid : v1_ff;
      v2_in = rdy2 ? v1_ff     : v2_ff;
      v3_in = rdy3 ? v2_ff     : v3_ff;
      v4_in = rdy4 ? v3_ff     : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: horizontal blend of both rows
   // ---------------------------------------------------------------
   logic [rbbd_pkg::PixelWidth-1:0]  s1_top_ff, s1_top_in;
   logic [rbbd_pkg::PixelWidth-1:0]  s1_bot_ff, s1_bot_in;
   logic [rbbd_pkg::WeightWidth-1:0] s1_wy_ff,  s1_wy_in;

   always_comb begin
      s1_top_in = rbbd_pkg::blend_pixel(req_top_left, req_top_right, req_weight_x);
      s1_bot_in = rbbd_pkg::blend_pixel(req_bottom_left, req_bottom_right, req_weight_x);
      s1_wy_in  = req_weight_y;
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_top_ff <= s1_top_in;
         s1_bot_ff <= s1_bot_in;
         s1_wy_ff  <= s1_wy_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: vertical blend of the row results
   // ---------------------------------------------------------------
   logic [rbbd_pkg::PixelWidth-1:0] s2_mix_ff, s2_mix_in;

   assign s2_mix_in = rbbd_pkg::blend_pixel(s1_top_ff, s1_bot_ff, s1_wy_ff);

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_mix_ff <= s2_mix_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: channel * percent + 50; 100 and above bypasses dimming
   // ---------------------------------------------------------------
   logic                            s3_pass_ff, s3_pass_in;
   logic [rbbd_pkg::PixelWidth-1:0] s3_pix_ff,  s3_pix_in;
   logic [12:0]                     s3_r_ff,    s3_r_in;
   logic [12:0]                     s3_g_ff,    s3_g_in;
   logic [12:0]                     s3_b_ff,    s3_b_in;

   always_comb begin
      s3_pass_in = (pct_ff >= rbbd_pkg::PercentFull);
      s3_pix_in  = s2_mix_ff;
      s3_r_in    = 13'(s2_mix_ff[15:11]) * 13'(pct_ff) + rbbd_pkg::PercentRound;
      s3_g_in    = 13'(s2_mix_ff[10:5])  * 13'(pct_ff) + rbbd_pkg::PercentRound;
      s3_b_in    = 13'(s2_mix_ff[4:0])   * 13'(pct_ff) + rbbd_pkg::PercentRound;
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_pass_ff <= s3_pass_in;
         s3_pix_ff  <= s3_pix_in;
         s3_r_ff    <= s3_r_in;
         s3_g_ff    <= s3_g_in;
         s3_b_ff    <= s3_b_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: divide by 100 through the reciprocal, or pass through
   // ---------------------------------------------------------------
   logic [25:0]                     q_r, q_g, q_b;
   logic [rbbd_pkg::PixelWidth-1:0] s4_pix_ff, s4_pix_in;

   always_comb begin
      q_r = 26'(s3_r_ff) * 26'(rbbd_pkg::RecipMul);
      q_g = 26'(s3_g_ff) * 26'(rbbd_pkg::RecipMul);
      q_b = 26'(s3_b_ff) * 26'(rbbd_pkg::RecipMul);
      if (s3_pass_ff) begin
         s4_pix_in = s3_pix_ff;
      end else begin
         s4_pix_in = {q_r[rbbd_pkg::RecipShift +: 5],
                      q_g[rbbd_pkg::RecipShift +: 6],
                      q_b[rbbd_pkg::RecipShift +: 5]};
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_pix_ff <= s4_pix_in;
      end
   end

   assign rsp_pixel_out = s4_pix_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rbbd_checker.sv =====
`default_nettype none

module rbbd_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [rbbd_pkg::PixelWidth-1:0]   rsp_pixel_out,
   input wire logic                              csr_psel,
   input wire logic                              csr_penable,
   input wire logic                              csr_pwrite,
   input wire logic [rbbd_pkg::CsrAddrWidth-1:0] csr_paddr,
   input wire logic [rbbd_pkg::CsrDataWidth-1:0] csr_pwdata,
   input wire logic [rbbd_pkg::CsrDataWidth-1:0] csr_prdata
);

   // Output is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_out))
      else $error("stalled result changed");

   // A free-running output never backpressures the input
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output is ready");

   // A transfer comes out of the last stage when the output never stalls
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && rsp_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
      |=> rsp_valid)
      else $error("result missing four cycles after transfer");

   // Brightness read back reflects the last write
   a_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite &&
       csr_paddr[2] == rbbd_pkg::BrightnessIndex)
      ##1 (csr_paddr[2] == rbbd_pkg::BrightnessIndex)
      |-> csr_prdata == rbbd_pkg::CsrDataWidth'($past(csr_pwdata[rbbd_pkg::PctWidth-1:0])))
      else $error("brightness read back mismatch");

endmodule

bind rgb565_bilinear_blend_dimmer rbbd_checker u_rbbd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_pixel_out (rsp_pixel_out),
   .csr_psel      (csr_psel),
   .csr_penable   (csr_penable),
   .csr_pwrite    (csr_pwrite),
   .csr_paddr     (csr_paddr),
   .csr_pwdata    (csr_pwdata),
   .csr_prdata    (csr_prdata)
);

`default_nettype wire

// ===== tb/rgb565_bilinear_blend_dimmer_tb.sv =====
`timescale 1ns / 100ps

module rgb565_bilinear_blend_dimmer_tb;

   typedef logic [rbbd_pkg::PixelWidth-1:0]  pixel_type;
   typedef logic [rbbd_pkg::WeightWidth-1:0] weight_type;

   // Register map: brightness at word 0, word 1 is unused and must be ignored
   localparam logic [rbbd_pkg::CsrAddrWidth-1:0] BrightnessAddr = 3'd0;
   localparam logic [rbbd_pkg::CsrAddrWidth-1:0] SpareAddr      = 3'd4;

   localparam int unsigned FullPercent  = 100;
   localparam int unsigned HalfPercent  = 50;
   localparam int unsigned UnitWeight   = 256;
   localparam int unsigned HalfWeight   = 128;
   localparam int          DrainCycles  = 12;
   localparam int          PhaseItems   = 175;
   localparam int          ReportLimit  = 10;

   // Predicts each output pixel from the four neighbors, the weights and the
   // brightness currently in force, and holds the pixels still to come.
   class pixel_tracker_type;
      logic [rbbd_pkg::PctWidth-1:0] brightness;
      pixel_type                     pending_pixels[$];
      int                            checked;
      int                            mismatches;

      function new();
         brightness = rbbd_pkg::BrightnessReset;
         checked    = 0;
         mismatches = 0;
      endfunction

      // Only word 0 holds a register; writes elsewhere drop on the floor
      function void write_reg(logic [rbbd_pkg::CsrAddrWidth-1:0] addr,
                              logic [rbbd_pkg::CsrDataWidth-1:0] data);
         if (addr[2] == rbbd_pkg::BrightnessIndex) begin
            brightness = data[rbbd_pkg::PctWidth-1:0];
         end
      endfunction

      function int unsigned mix_channel(int unsigned a, int unsigned b, weight_type w);
         int unsigned wt;
         wt = 32'(w);
         return (a * (UnitWeight - wt) + b * wt + HalfWeight) >> 8;
      endfunction

      function pixel_type mix_pixel(pixel_type a, pixel_type b, weight_type w);
         int unsigned r;
         int unsigned g;
         int unsigned bl;
         r  = mix_channel(32'(a[15:11]), 32'(b[15:11]), w);
         g  = mix_channel(32'(a[10:5]), 32'(b[10:5]), w);
         bl = mix_channel(32'(a[4:0]), 32'(b[4:0]), w);
         return {r[4:0], g[5:0], bl[4:0]};
      endfunction

      // Values at or above full scale pass the pixel untouched
      function pixel_type dim_pixel(pixel_type p);
         int unsigned pct;
         int unsigned r;
         int unsigned g;
         int unsigned bl;
         pct = 32'(brightness);
         if (pct >= FullPercent) begin
            return p;
         end
         r  = 32'(p[15:11]);
         g  = 32'(p[10:5]);
         bl = 32'(p[4:0]);
         r  = (r * pct + HalfPercent) / FullPercent;
         g  = (g * pct + HalfPercent) / FullPercent;
         bl = (bl * pct + HalfPercent) / FullPercent;
         return {r[4:0], g[5:0], bl[4:0]};
      endfunction

      function void note_request(pixel_type tl, pixel_type tr, pixel_type bl,
                                 pixel_type br, weight_type wx, weight_type wy);
         pixel_type upper;
         pixel_type lower;
         upper = mix_pixel(tl, tr, wx);
         lower = mix_pixel(bl, br, wx);
         pending_pixels.push_back(dim_pixel(mix_pixel(upper, lower, wy)));
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type want;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
               $display("[%0t] unexpected pixel 0x%04h with nothing outstanding", $time, got);
            end
            return;
         end
         want = pending_pixels.pop_front();
         checked++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
               $display("[%0t] pixel_out mismatch: expected 0x%04h, got 0x%04h",
                        $time, want, got);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid        = 1'b0;
   logic       req_ready;
   pixel_type  req_top_left     = '0;
   pixel_type  req_top_right    = '0;
   pixel_type  req_bottom_left  = '0;
   pixel_type  req_bottom_right = '0;
   weight_type req_weight_x     = '0;
   weight_type req_weight_y     = '0;

   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   pixel_type rsp_pixel_out;

   logic                              csr_psel    = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite  = 1'b0;
   logic [rbbd_pkg::CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [rbbd_pkg::CsrDataWidth-1:0] csr_pwdata  = '0;
   logic [rbbd_pkg::CsrDataWidth-1:0] csr_prdata;
   logic                              csr_pready;

   pixel_tracker_type tracker = new();

   // Gaps and stalls are enabled per stretch; zero means a clean stream
   bit idle_on = 1'b0;
   int pixels_sent = 0;
   int settings_run = 0;

   rgb565_bilinear_blend_dimmer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_top_left     (req_top_left),
      .req_top_right    (req_top_right),
      .req_bottom_left  (req_bottom_left),
      .req_bottom_right (req_bottom_right),
      .req_weight_x     (req_weight_x),
      .req_weight_y     (req_weight_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_out    (rsp_pixel_out),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the pipeline hangs
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // Check every result transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_pixel(rsp_pixel_out);
      end
   end

   // Result side backpressure: short stall bursts while idling is enabled
   initial begin
      forever begin
         if (!reset && idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Present one item, hold it until the transfer, then maybe leave a gap.
   // Valid stays high when no gap follows so back-to-back items stream.
   task automatic send_pixel(input pixel_type tl, input pixel_type tr,
                             input pixel_type bl, input pixel_type br,
                             input weight_type wx, input weight_type wy);
      req_valid        <= 1'b1;
      req_top_left     <= tl;
      req_top_right    <= tr;
      req_bottom_left  <= bl;
      req_bottom_right <= br;
      req_weight_x     <= wx;
      req_weight_y     <= wy;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(tl, tr, bl, br, wx, wy);
      pixels_sent++;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Drop valid, let every outstanding pixel come back, then settle
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (tracker.pending_pixels.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Two-phase register write; the write lands on the access cycle edge
   task automatic write_csr(input logic [rbbd_pkg::CsrAddrWidth-1:0] addr,
                            input logic [rbbd_pkg::CsrDataWidth-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.write_reg(addr, data);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Mostly full-range values, with channel extremes mixed in
   function automatic pixel_type pick_pixel();
      case ($urandom_range(0, 15))
         0:       return 16'hffff;
         1:       return 16'h0000;
         2:       return 16'hf800;
         3:       return 16'h07e0;
         4:       return 16'h001f;
         default: return pixel_type'($urandom_range(0, 16'hffff));
      endcase
   endfunction

   // Bias toward the edges of the weight range
   function automatic weight_type pick_weight();
      case ($urandom_range(0, 15))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd128;
         3:       return 8'd1;
         default: return weight_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_random_pixel();
      pixel_type tl;
      pixel_type tr;
      pixel_type bl;
      pixel_type br;
      tl = pick_pixel();
      tr = pick_pixel();
      bl = pick_pixel();
      br = pick_pixel();
      // Equal neighbors collapse a blend to the pixel itself
      case ($urandom_range(0, 15))
         0: begin
            tr = tl;
            br = bl;
         end
         1: begin
            tr = tl;
            bl = tl;
            br = tl;
         end
         2: begin
            bl = tl;
            br = tr;
         end
         default: ;
      endcase
      send_pixel(tl, tr, bl, br, pick_weight(), pick_weight());
   endtask

   initial begin : stimulus
      logic [rbbd_pkg::CsrDataWidth-1:0] levels[8];
      int                                phase;
      int                                n;

      // Extremes first; one value carries junk above the 7-bit field
      levels = '{32'd0, 32'd127, 32'd1, 32'hffff_ffa5, 32'd99, 32'd101, 32'd50, 32'd100};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass at reset brightness (full scale, pass-through)
      send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0);
      send_pixel(16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'd255, 8'd255);
      // Zero weights select the top-left neighbor exactly
      send_pixel(16'hffff, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0);
      send_pixel(16'h1234, 16'hffff, 16'hffff, 16'hffff, 8'd0, 8'd0);
      // Full weights lean almost completely toward bottom-right
      send_pixel(16'h0000, 16'h0000, 16'h0000, 16'hffff, 8'd255, 8'd255);
      send_pixel(16'hf800, 16'h07e0, 16'h001f, 16'hffff, 8'd128, 8'd128);
      send_pixel(16'h001f, 16'hf800, 16'h07e0, 16'h0000, 8'd1, 8'd254);
      // Equal neighbors yield the same pixel for any weights
      send_pixel(16'h5a5a, 16'h5a5a, 16'h5a5a, 16'h5a5a, 8'd77, 8'd200);
      send_pixel(16'hf81f, 16'hf81f, 16'h07e0, 16'h07e0, 8'd255, 8'd0);
      send_pixel(16'h0000, 16'hffff, 16'h0000, 16'hffff, 8'd128, 8'd0);
      send_pixel(16'h0000, 16'h0000, 16'hffff, 16'hffff, 8'd0, 8'd128);
      send_pixel(16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 8'haa, 8'h55);
      drain_pipeline();

      // Write to the unused word must leave brightness alone
      write_csr(SpareAddr, 32'd10);
      send_pixel(16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'd0, 8'd0);
      send_pixel(16'h8410, 16'h8410, 16'h8410, 16'h8410, 8'd64, 8'd192);
      drain_pipeline();

      // Zero brightness blanks everything
      write_csr(BrightnessAddr, 32'd0);
      settings_run++;
      send_pixel(16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'd255, 8'd0);
      send_pixel(16'hf800, 16'h07e0, 16'h001f, 16'hffff, 8'd33, 8'd99);
      drain_pipeline();

      // Random phases, one brightness each, drained before each write
      for (phase = 0; phase < 8; phase++) begin
         write_csr(BrightnessAddr, levels[phase]);
         settings_run++;
         for (n = 0; n < PhaseItems; n++) begin
            // Switch idling on and off in stretches; last phase runs clean
            if (n % 40 == 0) begin
               idle_on = (phase != 7) && ($urandom_range(0, 3) != 0);
            end
            // Hold off mid-phase once until the pipeline empties
            if (phase == 2 && n == PhaseItems / 2) begin
               drain_pipeline();
            end
            send_random_pixel();
         end
         drain_pipeline();
      end

      idle_on = 1'b0;
      $display("Sent %0d pixels across %0d brightness settings; %0d results checked, %0d bad.",
               pixels_sent, settings_run, tracker.checked, tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
